@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level module to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BDA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bda assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BDA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bda assertion failed");

`endif

@@ hdl/bda_pkg.sv @@
// Shared constants, types and command/status structs of the decimal text converter.
package bda_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int DIGITS        = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS      = DIGITS * 4;
   localparam int BIT_CNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_BITS  = $clog2(DIGITS + 1);
   localparam int IN_DATA_BITS  = 32;
   localparam int OUT_DATA_BITS = 8;
   localparam int CHAR_BITS     = 6;

   localparam logic [CHAR_BITS-1:0] DIGIT_ZERO = 6'd48;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic skip;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic top_zero;
      logic dig_last;
      logic out_free;
   } status_type;

endpackage

@@ hdl/bda_ctrl.sv @@
// Controller state machine that sequences loading, conversion and digit output.
module bda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  bda_pkg::status_type sts,
   output logic                req_tready,
   output bda_pkg::cmd_type    cmd
);

   bda_pkg::state_type state_ff;
   bda_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bda_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bda_pkg::ST_CONVERT;
            end
         end
         bda_pkg::ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (sts.conv_last) begin
               state_in = bda_pkg::ST_SKIP;
            end
         end
         bda_pkg::ST_SKIP: begin
            // Leading zeros are dropped, but the units digit always goes out.
            if (sts.top_zero && !sts.dig_last) begin
               cmd.skip = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.dig_last ? bda_pkg::ST_IDLE : bda_pkg::ST_EMIT;
            end else begin
               state_in = bda_pkg::ST_EMIT;
            end
         end
         bda_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.dig_last) begin
                  state_in = bda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/bda_datapath.sv @@
// Shift-and-add-3 converter registers, digit counters and the result register.
module bda_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bda_pkg::cmd_type                      cmd,
   input  logic [bda_pkg::IN_DATA_BITS-1:0]      req_tdata,
   input  logic                                  rsp_tready,
   output bda_pkg::status_type                   sts,
   output logic                                  rsp_tvalid,
   output logic [bda_pkg::OUT_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);

   logic [bda_pkg::VALUE_BITS-1:0]   bin_ff;
   logic [bda_pkg::BCD_BITS-1:0]     bcd_ff;
   logic [bda_pkg::BCD_BITS-1:0]     bcd_adj;
   logic [bda_pkg::BIT_CNT_BITS-1:0] bit_cnt_ff;
   logic [bda_pkg::DIG_CNT_BITS-1:0] dig_cnt_ff;
   logic [bda_pkg::CHAR_BITS-1:0]    char_ff;
   logic                             last_ff;
   logic                             valid_ff;
   logic [3:0]                       top_digit;

   assign top_digit = bcd_ff[bda_pkg::BCD_BITS-1 -: 4];

   // Add 3 to every BCD digit of 5 or more before the next doubling.
   always_comb begin
      logic [3:0] dig;
      dig     = 4'd0;
      bcd_adj = '0;
      for (int i = 0; i < bda_pkg::DIGITS; i++) begin
         dig              = bcd_ff[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff     <= bda_pkg::value_type'(req_tdata);
         bcd_ff     <= '0;
         bit_cnt_ff <= bda_pkg::BIT_CNT_BITS'(bda_pkg::VALUE_BITS);
         dig_cnt_ff <= bda_pkg::DIG_CNT_BITS'(bda_pkg::DIGITS);
      end else if (cmd.shift) begin
         {bcd_ff, bin_ff} <= {bcd_adj[bda_pkg::BCD_BITS-2:0], bin_ff, 1'b0};
         bit_cnt_ff       <= bit_cnt_ff - 1'b1;
      end else if (cmd.skip || cmd.emit) begin
         bcd_ff     <= {bcd_ff[bda_pkg::BCD_BITS-5:0], 4'd0};
         dig_cnt_ff <= dig_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= bda_pkg::DIGIT_ZERO + {2'b00, top_digit};
         last_ff <= (dig_cnt_ff == bda_pkg::DIG_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign sts.conv_last = (bit_cnt_ff == bda_pkg::BIT_CNT_BITS'(1));
   assign sts.top_zero  = (top_digit == 4'd0);
   assign sts.dig_last  = (dig_cnt_ff == bda_pkg::DIG_CNT_BITS'(1));
   assign sts.out_free  = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ hdl/binary_to_decimal_ascii_core.sv @@
// Top level of the binary to decimal ASCII converter.
// Each transfer on the req_ stream carries one unsigned 32-bit number; the
// block answers on the rsp_ stream with its decimal text, one ASCII digit
// ('0' to '9') per transfer, most significant digit first, with leading zeros
// dropped, so zero gives the single character '0'. rsp_tlast marks the final,
// least significant digit of each number, so a run holds 1 to 10 transfers.
// One number is handled at a time: after a req_ transfer, the shift-and-add-3
// converter shifts through all 32 input bits, then drops each leading zero
// digit, then emits one digit per cycle while the consumer keeps rsp_tready
// high. Without backpressure, the time from acceptance to the last digit does
// not depend on the value, and the next number can be taken in the cycle
// after the last digit is issued. The final digit sits in an output
// register, so req_tready rises again while that digit still waits to be
// taken. Nothing is kept from one number to the next, and there is no
// configuration.
module binary_to_decimal_ascii_core (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata fields, lowest bit first: value[31:0].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bda_pkg::IN_DATA_BITS-1:0]  req_tdata,
   // rsp_tdata fields, lowest bit first: digit_char[5:0], zero fill [7:6].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bda_pkg::OUT_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast
);

`include "assert_macros.svh"

   // Commands flow from the controller to the datapath; status flows back.
   bda_pkg::cmd_type    cmd;
   bda_pkg::status_type sts;

   bda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bda_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // After a number is taken, conversion starts and no new number is taken.
   `BDA_ASSERT_NXT(a_busy_after_load, clock, reset, req_tvalid && req_tready, !req_tready)

   // Every digit presented is a valid ASCII decimal digit.
   `BDA_ASSERT_IMP(a_digit_range, clock, reset, rsp_tvalid,
      rsp_tdata >= 8'd48 && rsp_tdata <= 8'd57)

   // While a run is still in progress, the next number cannot be accepted.
   `BDA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

endmodule
